// ----- hdl/ssar_pkg.sv -----
// Package for the strided slice axis resolver: item and result payload types,
// error codes, register map constants and the divider side-band record.
// No dependencies.
package ssar_pkg;

    localparam int DIV_BITS = 33;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [0:0] REG_END_IS_LAST = 1'b0;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_STEP      = 3'd1,
        ERR_ORDER     = 3'd2,
        ERR_COUNT     = 3'd3,
        ERR_START_NEG = 3'd4,
        ERR_START_BIG = 3'd5,
        ERR_END_LOW   = 3'd6,
        ERR_END_BIG   = 3'd7
    } err_t;

    typedef struct packed {
        logic [30:0]        axis_size;
        logic signed [31:0] axis_origin;
        logic               first_given;
        logic signed [31:0] first_coord;
        logic               extent_given;
        logic signed [31:0] extent_value;
        logic signed [31:0] step;
    } item_t;

    typedef struct packed {
        logic [2:0]         error_code;
        logic [30:0]        first_index;
        logic signed [31:0] last_index;
        logic [30:0]        result_count;
        logic [30:0]        out_step;
    } result_t;

    typedef struct packed {
        err_t        err;
        logic        is_div;
        logic [30:0] first_index;
        logic [30:0] size;
        logic [32:0] end_u;
        logic [31:0] alt_last;
        logic [30:0] alt_count;
    } side_t;

endpackage

// ----- hdl/strided_slice_axis_resolve.sv -----
// Top level of the strided slice axis resolver: decode, bound checks, a
// 33-stage pipelined divider, result stage and output skid buffer.
// Depends on ssar_pkg.
//
// The block takes one item per clock while item_ready is high and returns one
// result per item, in order. The restoring divider (one quotient bit per stage,
// 33 stages) computes the element count and the stride-snapped last index; an
// element-count end is resolved with one 32x32 multiplier stage instead. An
// output register and a one-entry skid buffer sit behind the pipeline, so
// item_ready drops only once a result is held in both. The end_is_last register
// (byte address 0) must be written only while no item is in flight.
module strided_slice_axis_resolve #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  ssar_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output ssar_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssar_pkg::PADDR_W-1:0]  paddr,
    input  logic [ssar_pkg::PDATA_W-1:0]  pwdata,
    output logic [ssar_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int IN_BITS   = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam bit IN_SIGNED = (COORD_WIDTH <= 32);
    localparam int NB        = ssar_pkg::DIV_BITS;

    function automatic logic signed [32:0] coord(input logic [31:0] f);
        logic [32:0] v;
        logic        s;
        s = IN_SIGNED ? f[IN_BITS-1] : 1'b0;
        for (int i = 0; i < 32; i++)
        begin
            v[i] = (i < IN_BITS) ? f[i] : s;
        end
        v[32] = s;
        return $signed(v);
    endfunction

    function automatic logic signed [34:0] sx35(input logic signed [32:0] a);
        return $signed({{2{a[32]}}, a});
    endfunction

    // configuration register
    logic end_is_last_reg;
    logic reg_sel;
    logic cfg_wr;

    assign reg_sel = (paddr[ssar_pkg::PADDR_W-1:2] == ssar_pkg::REG_END_IS_LAST);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(ssar_pkg::PDATA_W-1){1'b0}}, end_is_last_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_is_last_reg <= 1'b0;
        end
        else if (cfg_wr && reg_sel)
        begin
            end_is_last_reg <= pwdata[0];
        end
    end

    // pipeline advance
    logic skid_valid_reg;
    logic adv;

    assign adv        = !skid_valid_reg;
    assign item_ready = adv;

    // stage 1: decode, step, order and count checks
    logic signed [32:0] ext_c;
    logic signed [32:0] first_c;
    logic signed [32:0] org_c;
    logic signed [32:0] step_c;
    ssar_pkg::err_t     s1_err_next;
    logic signed [34:0] s1_start_next;
    logic signed [34:0] s1_end_last_next;

    logic               s1_valid_reg;
    ssar_pkg::err_t     s1_err_reg;
    logic signed [34:0] s1_start_reg;
    logic signed [34:0] s1_end_last_reg;
    logic [32:0]        s1_ext_reg;
    logic [31:0]        s1_ext_m1_reg;
    logic [31:0]        s1_step_reg;
    logic [30:0]        s1_size_reg;
    logic               s1_cnt_reg;
    logic               s1_lastm_reg;

    always_comb
    begin
        ext_c   = coord(item.extent_value);
        first_c = coord(item.first_coord);
        org_c   = coord(item.axis_origin);
        step_c  = coord(item.step);
        if (step_c[32] || step_c == '0)
        begin
            s1_err_next = ssar_pkg::ERR_STEP;
        end
        else if (end_is_last_reg)
        begin
            s1_err_next = (item.first_given && item.extent_given && ext_c < first_c)
                        ? ssar_pkg::ERR_ORDER : ssar_pkg::ERR_OK;
        end
        else
        begin
            s1_err_next = (item.extent_given && ext_c[32])
                        ? ssar_pkg::ERR_COUNT : ssar_pkg::ERR_OK;
        end
        s1_start_next    = item.first_given ? (sx35(first_c) - sx35(org_c)) : '0;
        s1_end_last_next = sx35(ext_c) - sx35(org_c);
    end

    // stage 2: start checks, end selection, span and count-mode product
    ssar_pkg::err_t     s2_err_next;
    logic signed [34:0] s2_end;
    logic signed [35:0] s2_n_next;

    logic               s2_valid_reg;
    ssar_pkg::err_t     s2_err_reg;
    logic [30:0]        s2_start_reg;
    logic [30:0]        s2_size_reg;
    logic [31:0]        s2_step_reg;
    logic               s2_cnt_reg;
    logic               s2_ext_zero_reg;
    logic [30:0]        s2_ext_lo_reg;
    logic [63:0]        s2_prod_reg;
    logic signed [35:0] s2_n_reg;
    logic [32:0]        s2_end_u_reg;

    always_comb
    begin
        if (s1_err_reg != ssar_pkg::ERR_OK)
        begin
            s2_err_next = s1_err_reg;
        end
        else if (s1_start_reg[34])
        begin
            s2_err_next = ssar_pkg::ERR_START_NEG;
        end
        else if (s1_start_reg[33:0] >= {3'b000, s1_size_reg})
        begin
            s2_err_next = ssar_pkg::ERR_START_BIG;
        end
        else
        begin
            s2_err_next = ssar_pkg::ERR_OK;
        end
        s2_end    = s1_lastm_reg ? s1_end_last_reg
                                 : ($signed({4'b0000, s1_size_reg}) - 35'sd1);
        s2_n_next = $signed({s2_end[34], s2_end}) - $signed({s1_start_reg[34], s1_start_reg});
    end

    // stage 3: classify and load the divider
    logic [64:0]        s3_sum;
    ssar_pkg::side_t    s3_side;

    always_comb
    begin
        s3_sum            = {34'd0, s2_start_reg} + {1'b0, s2_prod_reg};
        s3_side.err       = s2_err_reg;
        s3_side.is_div    = 1'b0;
        s3_side.first_index = s2_start_reg;
        s3_side.size      = s2_size_reg;
        s3_side.end_u     = s2_end_u_reg;
        s3_side.alt_last  = {1'b0, s2_start_reg} - 32'd1;
        s3_side.alt_count = '0;
        if (s2_err_reg == ssar_pkg::ERR_OK)
        begin
            if (s2_cnt_reg)
            begin
                if (!s2_ext_zero_reg)
                begin
                    if (s3_sum >= {34'd0, s2_size_reg})
                    begin
                        s3_side.err = ssar_pkg::ERR_END_BIG;
                    end
                    else
                    begin
                        s3_side.alt_last  = s3_sum[31:0];
                        s3_side.alt_count = s2_ext_lo_reg;
                    end
                end
            end
            else if (s2_n_reg < -36'sd1)
            begin
                s3_side.err = ssar_pkg::ERR_END_LOW;
            end
            else if (s2_n_reg != -36'sd1)
            begin
                s3_side.is_div = 1'b1;
            end
        end
    end

    // divider: one quotient bit per stage
    logic [NB:0]     dv_valid_reg;
    logic [31:0]     dv_rem_reg  [NB+1];
    logic [NB-1:0]   dv_num_reg  [NB+1];
    logic [31:0]     dv_div_reg  [NB+1];
    ssar_pkg::side_t dv_side_reg [NB+1];
    logic [32:0]     dv_trial    [NB];
    logic [32:0]     dv_diff     [NB];
    logic            dv_fits     [NB];
    logic [31:0]     dv_rem_next [NB];
    logic [NB-1:0]   dv_num_next [NB];

    always_comb
    begin
        for (int k = 0; k < NB; k++)
        begin
            dv_trial[k]    = {dv_rem_reg[k], dv_num_reg[k][NB-1]};
            dv_diff[k]     = dv_trial[k] - {1'b0, dv_div_reg[k]};
            dv_fits[k]     = dv_trial[k] >= {1'b0, dv_div_reg[k]};
            dv_rem_next[k] = dv_fits[k] ? dv_diff[k][31:0] : dv_trial[k][31:0];
            dv_num_next[k] = {dv_num_reg[k][NB-2:0], dv_fits[k]};
        end
    end

    // result stage
    ssar_pkg::result_t fin_next;
    ssar_pkg::err_t    fin_err;
    logic [32:0]       fin_last;
    logic              fin_big;
    logic              fin_valid_reg;
    ssar_pkg::result_t fin_reg;

    always_comb
    begin
        fin_last = dv_side_reg[NB].end_u - {1'b0, dv_rem_reg[NB]};
        fin_big  = fin_last >= {2'b00, dv_side_reg[NB].size};
        fin_err  = dv_side_reg[NB].err;
        fin_next = '0;
        if (fin_err == ssar_pkg::ERR_OK && dv_side_reg[NB].is_div && fin_big)
        begin
            fin_err = ssar_pkg::ERR_END_BIG;
        end
        else if (fin_err == ssar_pkg::ERR_OK)
        begin
            fin_next.first_index = dv_side_reg[NB].first_index;
            fin_next.out_step    = dv_div_reg[NB][30:0];
            if (dv_side_reg[NB].is_div)
            begin
                fin_next.last_index   = $signed(fin_last[31:0]);
                fin_next.result_count = dv_num_reg[NB][30:0] + 31'd1;
            end
            else
            begin
                fin_next.last_index   = $signed(dv_side_reg[NB].alt_last);
                fin_next.result_count = dv_side_reg[NB].alt_count;
            end
        end
        fin_next.error_code = fin_err;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= item_valid;
            s2_valid_reg  <= s1_valid_reg;
            dv_valid_reg  <= {dv_valid_reg[NB-1:0], s2_valid_reg};
            fin_valid_reg <= dv_valid_reg[NB];
        end
    end

    // payload; hold on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_err_reg      <= s1_err_next;
            s1_start_reg    <= s1_start_next;
            s1_end_last_reg <= s1_end_last_next;
            s1_ext_reg      <= ext_c;
            s1_ext_m1_reg   <= ext_c[31:0] - 32'd1;
            s1_step_reg     <= step_c[31:0];
            s1_size_reg     <= item.axis_size;
            s1_cnt_reg      <= !end_is_last_reg && item.extent_given;
            s1_lastm_reg    <= end_is_last_reg && item.extent_given;

            s2_err_reg      <= s2_err_next;
            s2_start_reg    <= s1_start_reg[30:0];
            s2_size_reg     <= s1_size_reg;
            s2_step_reg     <= s1_step_reg;
            s2_cnt_reg      <= s1_cnt_reg;
            s2_ext_zero_reg <= (s1_ext_reg == '0);
            s2_ext_lo_reg   <= s1_ext_reg[30:0];
            s2_prod_reg     <= s1_ext_m1_reg * s1_step_reg;
            s2_n_reg        <= s2_n_next;
            s2_end_u_reg    <= s2_end[32:0];

            dv_rem_reg[0]   <= '0;
            dv_num_reg[0]   <= s2_n_reg[NB-1:0];
            dv_div_reg[0]   <= s2_step_reg;
            dv_side_reg[0]  <= s3_side;
            for (int k = 0; k < NB; k++)
            begin
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_num_reg[k+1]  <= dv_num_next[k];
                dv_div_reg[k+1]  <= dv_div_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end

            fin_reg <= fin_next;
        end
    end

    // output register and skid buffer
    logic              result_valid_reg;
    ssar_pkg::result_t result_reg;
    ssar_pkg::result_t skid_reg;
    logic              out_free;

    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end
            else
            begin
                result_valid_reg <= fin_valid_reg;
            end
        end
        else if (fin_valid_reg && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            result_reg <= skid_valid_reg ? skid_reg : fin_reg;
        end
        else if (adv)
        begin
            skid_reg <= fin_reg;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.error_code != ssar_pkg::ERR_OK
        |-> result_reg.first_index == '0 && result_reg.last_index == '0
            && result_reg.result_count == '0 && result_reg.out_step == '0)
        else $error("error result carries nonzero fields");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.error_code == ssar_pkg::ERR_OK
            && result_reg.result_count == '0
        |-> result_reg.last_index == $signed({1'b0, result_reg.first_index}) - 32'sd1)
        else $error("empty slice does not end one before its start");

    a_last_not_below: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.error_code == ssar_pkg::ERR_OK
            && result_reg.result_count != '0
        |-> result_reg.last_index >= $signed({1'b0, result_reg.first_index}))
        else $error("last index below first index");
`endif

endmodule

// ----- verif/strided_slice_axis_resolve_test.sv -----
// Self-checking testbench for strided_slice_axis_resolve: directed and random axis
// items in both end modes, checked one by one against an in-bench slice resolver.
// Depends on ssar_pkg and the strided_slice_axis_resolve RTL.
module strided_slice_axis_resolve_test;

    localparam longint COORD_MAX = 2147483647;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint SIZE_MAX  = 2147483647;
    localparam logic [ssar_pkg::PADDR_W-1:0] MODE_ADDR =
        ssar_pkg::PADDR_W'(4 * int'(ssar_pkg::REG_END_IS_LAST));

    class slice_scoreboard;
        ssar_pkg::result_t expected_slices[$];
        bit                last_mode;
        int                mismatches;

        function ssar_pkg::result_t resolve_axis(ssar_pkg::item_t it);
            ssar_pkg::result_t r;
            ssar_pkg::err_t    e;
            longint            size, origin, fc, ev, stp, start, stop, cnt;
            r = '0;
            e = ssar_pkg::ERR_OK;
            cnt = 0;
            size = longint'(it.axis_size);
            origin = longint'($signed(it.axis_origin));
            fc = longint'($signed(it.first_coord));
            ev = longint'($signed(it.extent_value));
            stp = longint'($signed(it.step));
            if (stp <= 0)
                e = ssar_pkg::ERR_STEP;
            else if (last_mode)
            begin
                if (it.first_given && it.extent_given && ev < fc)
                    e = ssar_pkg::ERR_ORDER;
            end
            else if (it.extent_given && ev < 0)
                e = ssar_pkg::ERR_COUNT;
            if (e == ssar_pkg::ERR_OK)
            begin
                start = it.first_given ? fc - origin : 0;
                if (start < 0)
                    e = ssar_pkg::ERR_START_NEG;
                else if (start >= size)
                    e = ssar_pkg::ERR_START_BIG;
                else
                begin
                    stop = size - 1;
                    if (it.extent_given)
                        stop = last_mode ? ev - origin : start + ev * stp - 1;
                    if (stop < start - 1)
                        e = ssar_pkg::ERR_END_LOW;
                    else if (stop >= start)
                    begin
                        cnt = 1 + (stop - start) / stp;
                        stop = start + (cnt - 1) * stp;
                    end
                    if (e == ssar_pkg::ERR_OK && stop >= size)
                        e = ssar_pkg::ERR_END_BIG;
                    if (e == ssar_pkg::ERR_OK)
                    begin
                        r.first_index = start[30:0];
                        r.last_index = stop[31:0];
                        r.result_count = cnt[30:0];
                        r.out_step = stp[30:0];
                    end
                end
            end
            r.error_code = e;
            return r;
        endfunction

        function void note_item(ssar_pkg::item_t it);
            expected_slices.push_back(resolve_axis(it));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(ssar_pkg::result_t got);
            ssar_pkg::result_t want;
            if (expected_slices.size() == 0)
            begin
                report_mismatch("result with no item pending");
                return;
            end
            want = expected_slices.pop_front();
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("error_code %0d, want %0d",
                                          got.error_code, want.error_code));
            if (got.first_index !== want.first_index)
                report_mismatch($sformatf("first_index %0d, want %0d",
                                          got.first_index, want.first_index));
            if (got.last_index !== want.last_index)
                report_mismatch($sformatf("last_index %0d, want %0d",
                                          $signed(got.last_index), $signed(want.last_index)));
            if (got.result_count !== want.result_count)
                report_mismatch($sformatf("result_count %0d, want %0d",
                                          got.result_count, want.result_count));
            if (got.out_step !== want.out_step)
                report_mismatch($sformatf("out_step %0d, want %0d",
                                          got.out_step, want.out_step));
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_ready;
    ssar_pkg::item_t              item = '0;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    ssar_pkg::result_t            result;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [ssar_pkg::PADDR_W-1:0] paddr = '0;
    logic [ssar_pkg::PDATA_W-1:0] pwdata = '0;
    logic [ssar_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    slice_scoreboard sb = new;
    bit              tx_bursty = 1'b1;
    bit              idle_off = 1'b0;

    strided_slice_axis_resolve dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.note_item(item);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    function automatic longint pick(longint lo, longint hi);
        longint r;
        r = longint'({$urandom, $urandom} >> 1);
        return lo + r % (hi - lo + 1);
    endfunction

    function automatic ssar_pkg::item_t axis_item(longint size, longint origin, bit fg,
                                                  longint fc, bit eg, longint ev,
                                                  longint stp);
        ssar_pkg::item_t it;
        it.axis_size = size[30:0];
        it.axis_origin = origin[31:0];
        it.first_given = fg;
        it.first_coord = fc[31:0];
        it.extent_given = eg;
        it.extent_value = ev[31:0];
        it.step = stp[31:0];
        return it;
    endfunction

    function automatic ssar_pkg::item_t random_item(bit last_mode);
        ssar_pkg::item_t it;
        longint          size, org, st, stp, ev, room;
        bit              fg, eg;
        if ($urandom_range(0, 4) == 0)
        begin
            it.axis_size = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 3))
                                                        : 31'($urandom);
            it.axis_origin = $urandom;
            it.first_given = 1'($urandom_range(0, 1));
            it.first_coord = $urandom;
            it.extent_given = 1'($urandom_range(0, 1));
            it.extent_value = $urandom;
            it.step = $urandom_range(0, 1) ? 32'($urandom_range(0, 8)) : 32'($urandom);
            return it;
        end
        case ($urandom_range(0, 3))
            0: size = pick(1, 16);
            1: size = pick(1, 1000);
            2: size = pick(1, SIZE_MAX);
            default: size = pick(SIZE_MAX - 1000, SIZE_MAX);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: stp = pick(1, 4);
            5, 6, 7: stp = pick(1, size);
            8: stp = pick(1, COORD_MAX);
            default: stp = pick(COORD_MIN, 0);
        endcase
        fg = $urandom_range(0, 3) != 0;
        eg = $urandom_range(0, 4) != 0;
        st = 0;
        if (fg)
        begin
            case ($urandom_range(0, 3))
                0: st = 0;
                1: st = size - 1;
                default: st = pick(0, size - 1);
            endcase
        end
        org = pick(COORD_MIN, COORD_MAX);
        if (org + st > COORD_MAX)
            org = COORD_MAX - st;
        room = size - st;
        if (last_mode)
        begin
            if ($urandom_range(0, 9) == 0)
                ev = org + st + pick(-3, room + 3);
            else
                ev = org + st + pick(-1, room - 1);
        end
        else
        begin
            if (stp > 0)
                room = (room + stp - 1) / stp;
            if ($urandom_range(0, 9) == 0)
                ev = pick(-3, room + 3);
            else
                ev = pick(0, room);
        end
        if (ev > COORD_MAX)
            ev = COORD_MAX;
        if (ev < COORD_MIN)
            ev = COORD_MIN;
        it = axis_item(size, org, fg, fg ? org + st : longint'($signed($urandom)),
                       eg, eg ? ev : longint'($signed($urandom)), stp);
        return it;
    endfunction

    task automatic send_item(input ssar_pkg::item_t it);
        if (!idle_off && tx_bursty && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic drain_slices();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_slices.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input bit last_mode);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MODE_ADDR;
        pwdata <= ssar_pkg::PDATA_W'(last_mode);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.last_mode = last_mode;
    endtask

    initial
    begin : result_pacing
        int seg;
        bit bursty;
        @(posedge clk);
        forever
        begin
            seg = $urandom_range(20, 300);
            bursty = $urandom_range(0, 2) != 0;
            repeat (seg)
            begin
                if (bursty && !idle_off && $urandom_range(0, 5) == 0)
                begin
                    result_ready <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count mode, reset value of the register
        send_item(axis_item(0, 0, 0, 0, 0, 0, 1));
        send_item(axis_item(10, 0, 0, 0, 0, 0, 0));
        send_item(axis_item(10, 0, 0, 0, 0, 0, COORD_MIN));
        send_item(axis_item(10, 0, 0, 0, 1, -1, 1));
        send_item(axis_item(10, 5, 1, 4, 0, 0, 1));
        send_item(axis_item(10, 5, 1, 15, 0, 0, 1));
        send_item(axis_item(10, 0, 0, 0, 1, 0, 3));
        send_item(axis_item(10, -3, 1, 2, 1, 0, 1));
        send_item(axis_item(10, 0, 1, 0, 1, 11, 1));
        send_item(axis_item(SIZE_MAX, 0, 0, 0, 0, 0, 1));
        send_item(axis_item(SIZE_MAX, COORD_MIN, 1, COORD_MAX, 0, 0, COORD_MAX));
        send_item(axis_item(SIZE_MAX, COORD_MAX, 1, COORD_MIN, 1, COORD_MAX, COORD_MAX));
        send_item(axis_item(SIZE_MAX, COORD_MIN, 1, COORD_MIN, 1, COORD_MAX, COORD_MAX));
        send_item(axis_item(100, 0, 1, 5, 1, 4, 10));
        send_item(axis_item(SIZE_MAX, -1, 1, -1, 1, 1, COORD_MAX));
        drain_slices();

        // last-index mode
        write_mode(1'b1);
        send_item(axis_item(10, 0, 1, COORD_MAX, 1, COORD_MIN, 1));
        send_item(axis_item(10, 0, 1, 5, 1, 4, 1));
        send_item(axis_item(10, 7, 0, 0, 1, 6, 2));
        send_item(axis_item(10, 7, 0, 0, 1, 5, 2));
        send_item(axis_item(10, 0, 1, 3, 1, 10, 1));
        send_item(axis_item(100, -10, 1, -7, 1, 40, 7));
        send_item(axis_item(50, 0, 1, 2, 0, 0, 4));
        send_item(axis_item(10, 0, 0, 0, 1, COORD_MIN, 0));
        send_item(axis_item(SIZE_MAX, COORD_MIN, 1, COORD_MIN, 1, COORD_MAX, 1));
        send_item(axis_item(SIZE_MAX, COORD_MIN, 1, COORD_MIN, 1, -2, 3));

        for (int ph = 0; ph < 8; ph++)
        begin
            drain_slices();
            write_mode(ph % 2 == 0);
            idle_off = (ph == 7);
            for (int n = 0; n < 250; n++)
            begin
                if (n % 50 == 0)
                    tx_bursty = $urandom_range(0, 2) != 0;
                send_item(random_item(sb.last_mode));
            end
        end

        drain_slices();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
